FILE: rtl/core/stk_pkg.sv
// stk_pkg: shared types and constants for the streaming top-k selector
// used by stk_ctrl, stk_datapath and stream_top_k_select; no dependencies
package stk_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned CfgW       = 5;
  localparam int unsigned RankW      = 4;
  localparam int unsigned ResultLim  = 16;
  localparam int unsigned DefMaxKeep = 16;
  localparam logic [CfgW-1:0] KeepReset = CfgW'(16);

  // one input word
  typedef struct packed {
    logic signed [ValueW-1:0] in_value;
    logic                     end_of_set;
  } stk_in_t;

  // one result word
  typedef struct packed {
    logic signed [ValueW-1:0] out_value;
    logic [RankW-1:0]         out_rank;
    logic                     out_last;
  } stk_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic emit;
    logic cfg_wr;
  } stk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_last;
  } stk_status_t;

endpackage

FILE: rtl/core/stream_top_k_select.sv
// stream_top_k_select: top level of the streaming top-k selector
// instantiates stk_ctrl and stk_datapath; types from stk_pkg
//
// Keeps the keep_count largest signed 32-bit values of a set in a row of
// registers sorted in descending order. A word is taken when start is high
// and busy is low; an ordinary word is inserted as it is taken, by a compare
// against every kept entry and a one-place shift. A word carrying end_of_set
// is inserted likewise and then the kept values come out one per cycle,
// largest first, from the head of the row, which shifts up by one place for
// each result; busy stays high until the last of them. Their number is the
// number of values held, at most the effective count, that is keep_count
// with zero taken as one and large values saturated. Each result is shown
// for exactly one cycle with out_strobe_o and cannot be held off. The fill
// count is cleared after the last result. keep_count is written on its own
// valid/ready channel while the block is idle; zero acts as one and values
// above MAX_KEEP or 16 saturate. Nothing needs clearing after reset: unused
// entries are never read.
module stream_top_k_select #(
  parameter int unsigned MAX_KEEP = stk_pkg::DefMaxKeep
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input words
  input  logic                     start,
  output logic                     busy,
  input  stk_pkg::stk_in_t         in_word_i,
  // results
  output logic                     out_strobe_o,
  output stk_pkg::stk_out_t        out_word_o,
  // keep_count write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [stk_pkg::CfgW-1:0] cfg_data_i
);

  stk_pkg::stk_cmd_t    cmd;
  stk_pkg::stk_status_t status;

  // sequencing: accept, emission, config write
  stk_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .end_of_set_i (in_word_i.end_of_set),
    .cfg_valid_i  (cfg_valid_i),
    .status_i     (status),
    .busy_o       (busy),
    .cfg_ready_o  (cfg_ready_o),
    .strobe_o     (out_strobe_o),
    .cmd_o        (cmd)
  );

  // sorted row, fill count, rank counter and keep_count register
  stk_datapath #(
    .MAX_KEEP (MAX_KEEP)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .cfg_data_i (cfg_data_i),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

`ifndef SYNTH
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> (busy && !cfg_ready_o))
    else $error("result shown while block idle");
`endif

endmodule

FILE: rtl/core/stk_ctrl.sv
// stk_ctrl: control state machine of the top-k selector
// depends on stk_pkg for the command and status structs
module stk_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                end_of_set_i,
  input  logic                cfg_valid_i,
  input  stk_pkg::stk_status_t status_i,
  output logic                busy_o,
  output logic                cfg_ready_o,
  output logic                strobe_o,
  output stk_pkg::stk_cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign busy_o      = (state_q == StEmit);
  assign cfg_ready_o = ~busy_o;
  assign strobe_o    = (state_q == StEmit);

  assign cmd_o.accept = start_i & ~busy_o;
  assign cmd_o.emit   = (state_q == StEmit);
  assign cmd_o.cfg_wr = cfg_valid_i & cfg_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.accept && end_of_set_i) state_d = StEmit;
      end
      StEmit: begin
        if (status_i.emit_last) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_end_starts_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && end_of_set_i) |=> (state_q == StEmit))
    else $error("end of set did not start emission");
  a_last_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && status_i.emit_last) |=> !busy_o)
    else $error("block still busy after last result");
`endif

endmodule

FILE: rtl/core/stk_datapath.sv
// stk_datapath: sorted keep row with parallel compare and shift, fill count, rank
// depends on stk_pkg; driven by stk_ctrl commands
module stk_datapath #(
  parameter int unsigned MAX_KEEP = stk_pkg::DefMaxKeep
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  stk_pkg::stk_cmd_t          cmd_i,
  input  stk_pkg::stk_in_t           in_word_i,
  input  logic [stk_pkg::CfgW-1:0]   cfg_data_i,
  output stk_pkg::stk_status_t       status_o,
  output stk_pkg::stk_out_t          out_word_o
);

  localparam int unsigned FW   = $clog2(MAX_KEEP + 1);
  localparam int unsigned IW   = $clog2(MAX_KEEP);
  localparam int unsigned KMAX = (MAX_KEEP < stk_pkg::ResultLim) ? MAX_KEEP
                                                                  : stk_pkg::ResultLim;

  logic signed [stk_pkg::ValueW-1:0] kept_q [MAX_KEEP];
  logic signed [stk_pkg::ValueW-1:0] kept_d [MAX_KEEP];
  logic [FW-1:0]                     fill_q, fill_d;
  logic [stk_pkg::CfgW-1:0]          keep_q;
  logic [stk_pkg::RankW-1:0]         rank_q;
  logic [stk_pkg::RankW:0]           rank_p1;

  logic [FW-1:0]       k_w;
  logic [IW-1:0]       k_m1;
  logic [FW-1:0]       fill_eff;
  logic [FW-1:0]       len_w;
  logic [MAX_KEEP-1:0] ge;
  logic                do_ins;
  logic signed [stk_pkg::ValueW-1:0] v;

  assign v = in_word_i.in_value;

  // effective k: zero acts as one, large values saturate
  always_comb begin
    if (keep_q == '0) begin
      k_w = FW'(1);
    end else if (32'(keep_q) > KMAX) begin
      k_w = FW'(KMAX);
    end else begin
      k_w = FW'(keep_q);
    end
  end

  assign k_m1     = IW'(k_w - FW'(1));
  assign fill_eff = (fill_q > k_w) ? k_w : fill_q;
  assign len_w    = (fill_eff < k_w) ? fill_eff : FW'(k_m1);
  assign do_ins   = (fill_eff < k_w) | ~ge[k_m1];

  // sorted descending, so ge is a run of ones from the head
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_row
    logic prev_ge;
    logic signed [stk_pkg::ValueW-1:0] prev_val;
    logic signed [stk_pkg::ValueW-1:0] next_val;
    logic in_lo, at_or_below;

    assign ge[i] = (kept_q[i] >= v);

    if (i == 0) begin : g_head
      assign prev_ge  = 1'b1;
      assign prev_val = kept_q[0];
    end else begin : g_body
      assign prev_ge  = ge[i-1];
      assign prev_val = kept_q[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign next_val = kept_q[i];
    end else begin : g_mid
      assign next_val = kept_q[i+1];
    end

    assign in_lo       = (32'(i) < 32'(len_w));
    assign at_or_below = (32'(i) <= 32'(len_w));

    always_comb begin
      kept_d[i] = kept_q[i];
      if (cmd_i.emit) begin
        kept_d[i] = next_val;
      end else if (cmd_i.accept && do_ins && at_or_below) begin
        if (in_lo && ge[i]) begin
          kept_d[i] = kept_q[i];
        end else if (prev_ge) begin
          kept_d[i] = v;
        end else begin
          kept_d[i] = prev_val;
        end
      end
    end
  end

  assign rank_p1            = {1'b0, rank_q} + 1'b1;
  assign status_o.emit_last = (rank_p1 == (stk_pkg::RankW + 1)'(fill_q));

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.emit) begin
      if (status_o.emit_last) fill_d = '0;
    end else if (cmd_i.accept) begin
      fill_d = (fill_eff < k_w) ? fill_eff + FW'(1) : fill_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_KEEP; j++) begin
      kept_q[j] <= kept_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      keep_q <= stk_pkg::KeepReset;
      rank_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (cmd_i.cfg_wr) keep_q <= cfg_data_i;
      if (cmd_i.accept) begin
        rank_q <= '0;
      end else if (cmd_i.emit) begin
        rank_q <= rank_q + 1'b1;
      end
    end
  end

  assign out_word_o.out_value = kept_q[0];
  assign out_word_o.out_rank  = rank_q;
  assign out_word_o.out_last  = status_o.emit_last;

`ifndef SYNTH
  a_fill_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && status_o.emit_last) |=> (fill_q == '0))
    else $error("fill count not cleared after last result");
  a_rank_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !status_o.emit_last) |=> (rank_q == $past(rank_q) + 1'b1))
    else $error("rank did not advance");
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && !cmd_i.emit) |=> (fill_q != '0))
    else $error("accepted word left the row empty");
`endif

endmodule

FILE: test/tb.sv
// tb: self-checking testbench for stream_top_k_select, the streaming top-k selector
// depends on stk_pkg and stream_top_k_select; runs directed sets, then random sets
// with random keep_count settings and random idling
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  // the block is built with its default depth, so the predictor uses the same limit
  localparam int unsigned MaxKeep  = stk_pkg::DefMaxKeep;
  localparam int unsigned NumWords = 500;

  typedef logic signed [stk_pkg::ValueW-1:0] value_t;
  typedef logic [stk_pkg::CfgW-1:0]          count_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  stk_pkg::stk_in_t   in_word;
  logic               out_strobe_o;
  stk_pkg::stk_out_t  out_word;
  logic               cfg_valid;
  logic               cfg_ready_o;
  count_t             cfg_data;

  // predictor state: the kept values in descending order and how many are valid
  value_t             kept_desc [MaxKeep];
  int unsigned        kept_fill;
  count_t             keep_count_q;

  // ranked results still owed by the block, oldest first
  stk_pkg::stk_out_t  ranked_q [$];

  int unsigned        mismatch_count;
  int unsigned        words_sent;
  bit                 idle_on;

  stream_top_k_select u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .in_word_i    (in_word),
    .out_strobe_o (out_strobe_o),
    .out_word_o   (out_word),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data)
  );

  // 20 ns clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard limit on the run, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one line per mismatch
  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // effective k: zero acts as one, anything above the depth or 16 saturates
  function automatic int unsigned keep_limit();
    int unsigned k;
    k = keep_count_q;
    if (k < 1) k = 1;
    if (k > MaxKeep) k = MaxKeep;
    if (k > stk_pkg::ResultLim) k = stk_pkg::ResultLim;
    return k;
  endfunction

  // place v into the first len sorted entries, after any equal values
  function automatic void place_sorted(input value_t v, input int unsigned len);
    int unsigned pos;
    pos = len;
    while (pos > 0 && kept_desc[pos-1] < v) begin
      kept_desc[pos] = kept_desc[pos-1];
      pos--;
    end
    kept_desc[pos] = v;
  endfunction

  // predictor: takes one accepted word and queues the ranked results it causes
  function automatic void rank_word(input stk_pkg::stk_in_t w);
    int unsigned       k;
    stk_pkg::stk_out_t r;
    k = keep_limit();
    // a lowered count drops the smallest kept values first
    if (kept_fill > k) kept_fill = k;
    if (kept_fill < k) begin
      place_sorted(w.in_value, kept_fill);
      kept_fill++;
    end else if (w.in_value > kept_desc[k-1]) begin
      // strictly greater only: an equal value leaves the smallest in place
      place_sorted(w.in_value, k - 1);
    end
    if (w.end_of_set) begin
      for (int unsigned i = 0; i < kept_fill; i++) begin
        r.out_value = kept_desc[i];
        r.out_rank  = i[stk_pkg::RankW-1:0];
        r.out_last  = (i + 1 == kept_fill);
        ranked_q.push_back(r);
      end
      kept_fill = 0;
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // values biased towards the extremes and towards small clustered values,
  // which give plenty of equal values
  function automatic value_t pick_value();
    int unsigned sel;
    int          small_v;
    sel     = $urandom_range(0, 9);
    small_v = $urandom_range(0, 8);
    case (sel)
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3, 4: return value_t'(small_v - 4);
      default: return value_t'($urandom);
    endcase
  endfunction

  // send one word: optional gap, then hold start until the word is taken.
  // start stays high after acceptance until the next falling edge, where the
  // caller either offers the next word or drops start
  task automatic send_word(input value_t v, input logic eos);
    int unsigned      gap;
    stk_pkg::stk_in_t w;
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      start   = 1'b0;
      in_word = stk_pkg::stk_in_t'({$urandom, 1'($urandom)});
      repeat (gap - 1) @(negedge clk_i);
    end
    w.in_value   = v;
    w.end_of_set = eos;
    @(negedge clk_i);
    start   = 1'b1;
    in_word = w;
    do @(posedge clk_i); while (busy !== 1'b0);
    rank_word(w);
    words_sent++;
  endtask

  // drop start and wait until no result is owed and the block has settled
  task automatic wait_idle();
    @(negedge clk_i);
    start = 1'b0;
    while (ranked_q.size() != 0) @(posedge clk_i);
    // an ordinary word may still be finishing its insertion
    repeat (3) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  // write keep_count on its own channel, only while the block is idle
  task automatic write_keep_count(input count_t val);
    wait_idle();
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data  = val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    keep_count_q = val;
    @(negedge clk_i);
    cfg_valid = 1'b0;
    cfg_data  = count_t'($urandom);
  endtask

  // checker: every strobed result against the oldest owed result
  always @(posedge clk_i) begin
    stk_pkg::stk_out_t exp_r;
    if (rst_ni && out_strobe_o === 1'b1) begin
      if (ranked_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d rank %0d",
                                  out_word.out_value, out_word.out_rank));
      end else begin
        exp_r = ranked_q.pop_front();
        if (out_word.out_value !== exp_r.out_value)
          report_mismatch($sformatf("value %0d, expected %0d",
                                    out_word.out_value, exp_r.out_value));
        if (out_word.out_rank !== exp_r.out_rank)
          report_mismatch($sformatf("rank %0d, expected %0d",
                                    out_word.out_rank, exp_r.out_rank));
        if (out_word.out_last !== exp_r.out_last)
          report_mismatch($sformatf("last %b, expected %b",
                                    out_word.out_last, exp_r.out_last));
      end
    end
  end

  // full-scale extremes at the reset count of 16, then a one-word set
  task automatic test_extremes();
    send_word(32'sh7fff_ffff, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh0000_0000, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd1, 1'b1);
    send_word(32'sd42, 1'b1);
  endtask

  // count of zero behaves as one
  task automatic test_count_zero();
    write_keep_count(count_t'(0));
    send_word(32'sd7, 1'b0);
    send_word(-32'sd3, 1'b0);
    send_word(32'sd9, 1'b1);
  endtask

  // equal values sit together and an equal value never displaces the smallest
  task automatic test_equal_values();
    write_keep_count(count_t'(2));
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(32'sd5, 1'b0);
    send_word(32'sd6, 1'b1);
  endtask

  // count lowered part way through a set trims the smallest kept values
  task automatic test_count_lowered();
    write_keep_count(count_t'(6));
    send_word(32'sd10, 1'b0);
    send_word(-32'sd20, 1'b0);
    send_word(32'sd30, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(32'sd15, 1'b0);
    write_keep_count(count_t'(2));
    send_word(32'sd12, 1'b0);
    send_word(-32'sd1, 1'b1);
  endtask

  // counts above 16 saturate
  task automatic test_count_saturation();
    write_keep_count(count_t'(31));
    send_word(32'sd3, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(32'sh7fff_ffff, 1'b0);
    send_word(32'sd3, 1'b1);
  endtask

  // random sets under a run of counts, extremes first; some phases without idling,
  // and now and then the count changes part way through a set
  task automatic test_random_sets();
    int unsigned phase;
    int unsigned num_sets;
    int unsigned set_len;
    int unsigned split_at;
    int unsigned r;
    phase = 0;
    while (words_sent < NumWords + 25) begin
      case (phase)
        0:       write_keep_count(count_t'(1));
        1:       write_keep_count(count_t'(16));
        2:       write_keep_count(count_t'(31));
        3:       write_keep_count(count_t'(0));
        default: write_keep_count(count_t'($urandom_range(0, 31)));
      endcase
      idle_on  = ($urandom_range(0, 3) != 0);
      num_sets = $urandom_range(3, 8);
      for (int unsigned s = 0; s < num_sets; s++) begin
        r = $urandom_range(0, 99);
        if (r < 70)      set_len = $urandom_range(1, keep_limit() + 3);
        else if (r < 90) set_len = $urandom_range(1, 40);
        else             set_len = 1;
        // a count change part way through roughly one set in twelve
        split_at = ($urandom_range(0, 11) == 0 && set_len > 1) ?
                   $urandom_range(1, set_len - 1) : set_len;
        for (int unsigned j = 0; j < set_len; j++) begin
          if (j == split_at) write_keep_count(count_t'($urandom_range(0, 31)));
          send_word(pick_value(), j + 1 == set_len);
        end
      end
      phase++;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    in_word        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    kept_fill      = 0;
    keep_count_q   = stk_pkg::KeepReset;
    mismatch_count = 0;
    words_sent     = 0;
    idle_on        = 1'b1;
    // reset held low from the start, then released on a falling edge, away from the rising edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_count_zero();
    test_equal_values();
    test_count_lowered();
    test_count_saturation();
    test_random_sets();

    // drain: everything owed must arrive, then the bench idles to catch strays
    wait_idle();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && ranked_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
